FILE: sv/bms_pkg.sv
// Package for the byte merge sorter.
// Buffer geometry, pointer widths and sequencer state codes.
// No dependencies.
package bms_pkg;

   localparam int BUF_DEPTH = 64;
   localparam int ADDR_W    = 6;
   localparam int PTR_W     = 7;
   localparam int SUM_W     = 8;
   localparam int STATE_W   = 3;

   typedef logic [7:0]         byte_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [STATE_W-1:0] state_type;

   localparam state_type ST_IDLE  = 3'd0;
   localparam state_type ST_PASS  = 3'd1;
   localparam state_type ST_PAIR  = 3'd2;
   localparam state_type ST_FETCH = 3'd3;
   localparam state_type ST_MOVE  = 3'd4;
   localparam state_type ST_OREAD = 3'd5;
   localparam state_type ST_OSHOW = 3'd6;

endpackage

FILE: sv/byte_merge_sorter.sv
// Byte merge sorter top level: loads a run of bytes, sorts it with a
// bottom-up stable merge sort over two ping-pong buffers, then emits it.
// Depends on bms_pkg.
//
//   channel   ports                                           direction
//   req       req_valid/req_stall, req_data_byte, req_last_in  in
//   rsp       rsp_valid/rsp_stall, rsp_sorted_byte,
//             rsp_last_out, rsp_overflow                      out
//
// Loading accepts one byte per cycle while idle. After the last byte, each
// merge pass fetches and moves one byte at a time through the single
// compare-and-move unit and the registered buffer read; there are
// ceil(log2 n) passes. Each result is then read from the buffer and
// held on rsp until it is taken.
// Synchronous reset clears the sequencer, the byte count and the overflow
// flag; buffer contents are not cleared. req_stall is high from the last
// byte of a run until its final result is taken.
module byte_merge_sorter
   import bms_pkg::*;
#(
   parameter int MAX_RUN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_sorted_byte,
   output logic       rsp_last_out,
   output logic       rsp_overflow
);

   localparam int CAP = (MAX_RUN > BUF_DEPTH) ? BUF_DEPTH : MAX_RUN;
   localparam ptr_type CAP_P = ptr_type'(CAP);

   byte_type  run_buf_ff   [BUF_DEPTH];
   byte_type  merge_buf_ff [BUF_DEPTH];

   state_type state_ff, state_in;
   ptr_type   count_ff, count_in;
   logic      ovf_ff, ovf_in;
   logic      src_ff, src_in;
   ptr_type   n_ff, n_in;
   ptr_type   w_ff, w_in;
   ptr_type   lo_ff, lo_in;
   ptr_type   mid_ff, mid_in;
   ptr_type   hi_ff, hi_in;
   ptr_type   a_ff, a_in;
   ptr_type   b_ff, b_in;
   ptr_type   k_ff, k_in;

   byte_type  rd0a_ff, rd0b_ff, rd1a_ff, rd1b_ff;
   byte_type  rd_a, rd_b;
   addr_type  addr_a, addr_b, wr_addr;
   byte_type  wr_data;
   logic      we0, we1;
   logic      req_acc, rsp_acc, store, take_a;
   sum_type   mid_sum, hi_sum, n_ext;
   ptr_type   k_nx;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign store   = req_acc && (count_ff < CAP_P);

   assign rd_a = src_ff ? rd1a_ff : rd0a_ff;
   assign rd_b = src_ff ? rd1b_ff : rd0b_ff;

   assign take_a = (a_ff < mid_ff) && (!(b_ff < hi_ff) || (rd_a <= rd_b));

   assign n_ext   = {1'b0, n_ff};
   assign mid_sum = {1'b0, lo_ff} + {1'b0, w_ff};
   assign hi_sum  = {1'b0, lo_ff} + {w_ff, 1'b0};
   assign k_nx    = k_ff + ptr_type'(1);

   // read addresses: merge heads, or the output index held in k
   assign addr_a = (state_ff == ST_OREAD || state_ff == ST_OSHOW) ? k_ff[ADDR_W-1:0]
                                                                 : a_ff[ADDR_W-1:0];
   assign addr_b = b_ff[ADDR_W-1:0];

   always_comb begin
      we0     = 1'b0;
      we1     = 1'b0;
      wr_addr = k_ff[ADDR_W-1:0];
      wr_data = take_a ? rd_a : rd_b;
      if (state_ff == ST_IDLE) begin
         we0     = store;
         wr_addr = count_ff[ADDR_W-1:0];
         wr_data = req_data_byte;
      end else if (state_ff == ST_MOVE) begin
         we0 = src_ff;
         we1 = !src_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         run_buf_ff[wr_addr] <= wr_data;
      end
      rd0a_ff <= run_buf_ff[addr_a];
      rd0b_ff <= run_buf_ff[addr_b];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         merge_buf_ff[wr_addr] <= wr_data;
      end
      rd1a_ff <= merge_buf_ff[addr_a];
      rd1b_ff <= merge_buf_ff[addr_b];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      src_in   = src_ff;
      n_in     = n_ff;
      w_in     = w_ff;
      lo_in    = lo_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (store) begin
                  count_in = count_ff + ptr_type'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_in) begin
                  n_in     = store ? count_ff + ptr_type'(1) : count_ff;
                  src_in   = 1'b0;
                  w_in     = ptr_type'(1);
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            lo_in = '0;
            k_in  = '0;
            if (w_ff >= n_ff) begin
               state_in = ST_OREAD;
            end else begin
               state_in = ST_PAIR;
            end
         end
         ST_PAIR: begin
            if (lo_ff >= n_ff) begin
               w_in     = {w_ff[PTR_W-2:0], 1'b0};
               src_in   = !src_ff;
               state_in = ST_PASS;
            end else begin
               mid_in   = (mid_sum > n_ext) ? n_ff : mid_sum[PTR_W-1:0];
               hi_in    = (hi_sum > n_ext) ? n_ff : hi_sum[PTR_W-1:0];
               a_in     = lo_ff;
               b_in     = (mid_sum > n_ext) ? n_ff : mid_sum[PTR_W-1:0];
               k_in     = lo_ff;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            if (take_a) begin
               a_in = a_ff + ptr_type'(1);
            end else begin
               b_in = b_ff + ptr_type'(1);
            end
            k_in = k_nx;
            if (k_nx == hi_ff) begin
               lo_in    = hi_ff;
               state_in = ST_PAIR;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_OREAD: begin
            state_in = ST_OSHOW;
         end
         ST_OSHOW: begin
            if (rsp_acc) begin
               k_in = k_nx;
               if (k_nx == n_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_OREAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      n_ff   <= n_in;
      w_ff   <= w_in;
      lo_ff  <= lo_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OSHOW);
   assign rsp_sorted_byte = rd_a;
   assign rsp_last_out    = (k_nx == n_ff);
   assign rsp_overflow    = ovf_ff;

endmodule

FILE: sim/testbench.sv
// Testbench for byte_merge_sorter: loads runs of bytes through req, checks each sorted
// byte on rsp against an in-bench stable insertion-sort predictor or a directed expectation, with random idling.
// Depends on bms_pkg and byte_merge_sorter.
module testbench
   import bms_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_CAP     = 64;
   localparam int HELD_CAP    = (RUN_CAP > BUF_DEPTH) ? BUF_DEPTH : RUN_CAP;
   localparam int RANDOM_ITEMS = 230;
   localparam int QUIET_LIMIT = 6000;
   localparam int DRAIN_CYCLES = 50;

   typedef struct packed {
      byte_type value;
      logic     last;
      logic     cut;
   } sorted_result_type;

   typedef struct packed {
      logic [6:0] count;
      byte_type   data;
      logic       last;
      logic       known;
      byte_type   exp_value;
      logic [6:0] exp_len;
      logic       exp_cut;
   } stim_row_type;

   localparam stim_row_type DIRECTED [21] = '{
      '{7'd1,  8'h00, 1'b1, 1'b1, 8'h00, 7'd1,  1'b0},
      '{7'd1,  8'hFF, 1'b1, 1'b1, 8'hFF, 7'd1,  1'b0},
      '{7'd1,  8'hFF, 1'b0, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'h00, 1'b1, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'h80, 1'b0, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'h7F, 1'b0, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'h01, 1'b0, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'hFE, 1'b0, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'h55, 1'b0, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'hAA, 1'b1, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd3,  8'h33, 1'b0, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'h33, 1'b1, 1'b1, 8'h33, 7'd4,  1'b0},
      '{7'd1,  8'h42, 1'b0, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'h17, 1'b0, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'h42, 1'b0, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'h17, 1'b1, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd63, 8'hC3, 1'b0, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'h3C, 1'b1, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd66, 8'hA5, 1'b0, 1'b0, 8'h00, 7'd0,  1'b0},
      '{7'd1,  8'h11, 1'b1, 1'b1, 8'hA5, 7'd64, 1'b1},
      '{7'd1,  8'h07, 1'b1, 1'b1, 8'h07, 7'd1,  1'b0}
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_last_in;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_sorted_byte;
   logic       rsp_last_out;
   logic       rsp_overflow;

   byte_type          held_run[$];
   logic              held_cut;
   byte_type          sorted_run[$];
   logic              sorted_cut;
   sorted_result_type expected_sorted[$];
   sorted_result_type head_result;
   int                sort_mismatches;
   logic              steady;

   byte_merge_sorter #(
      .MAX_RUN(RUN_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sorted_byte(rsp_sorted_byte),
      .rsp_last_out(rsp_last_out),
      .rsp_overflow(rsp_overflow)
   );

   always #5 clock = ~clock;

   function automatic bit take_byte(input byte_type value, input logic last);
      byte_type ordered[$];
      int       pos;
      if (held_run.size() < HELD_CAP) begin
         held_run.push_back(value);
      end else begin
         held_cut = 1'b1;
      end
      if (!last) begin
         return 1'b0;
      end
      ordered = {};
      foreach (held_run[i]) begin
         pos = ordered.size();
         while (pos > 0 && ordered[pos-1] > held_run[i]) pos--;
         ordered.insert(pos, held_run[i]);
      end
      sorted_run = ordered;
      sorted_cut = held_cut;
      held_run   = {};
      held_cut   = 1'b0;
      return 1'b1;
   endfunction

   task automatic issue_byte(input byte_type value, input logic last, input logic known,
                             input byte_type exp_value, input int exp_len,
                             input logic exp_cut);
      sorted_result_type entry;
      while (!steady && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      req_last_in   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (take_byte(value, last)) begin
         if (known) begin
            for (int i = 0; i < exp_len; i++) begin
               entry = '{exp_value, (i == exp_len - 1), exp_cut};
               expected_sorted.push_back(entry);
            end
         end else begin
            foreach (sorted_run[i]) begin
               entry = '{sorted_run[i], (i == sorted_run.size() - 1), sorted_cut};
               expected_sorted.push_back(entry);
            end
         end
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 25);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sorted.size() == 0) begin
            $display("%0t: unexpected result: byte %02h last %b overflow %b",
                     $time, rsp_sorted_byte, rsp_last_out, rsp_overflow);
            sort_mismatches++;
         end else begin
            head_result = expected_sorted.pop_front();
            if (rsp_sorted_byte !== head_result.value || rsp_last_out !== head_result.last
                || rsp_overflow !== head_result.cut) begin
               $display("%0t: expected byte %02h last %b overflow %b, got %02h %b %b",
                        $time, head_result.value, head_result.last, head_result.cut,
                        rsp_sorted_byte, rsp_last_out, rsp_overflow);
               sort_mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      int       sent_items;
      int       run_index;
      int       run_len;
      int       pick;
      bit       dup_mode;
      byte_type value;
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_byte   = '0;
      req_last_in     = 1'b0;
      rsp_stall       = 1'b0;
      steady          = 1'b0;
      held_cut        = 1'b0;
      sorted_cut      = 1'b0;
      sort_mismatches = 0;
      sent_items      = 0;
      run_index       = 0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[r]) begin
         repeat (DIRECTED[r].count) begin
            issue_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].known,
                       DIRECTED[r].exp_value, int'(DIRECTED[r].exp_len),
                       DIRECTED[r].exp_cut);
         end
      end

      // hold until the directed runs have drained
      req_valid <= 1'b0;
      while (expected_sorted.size() != 0) @(negedge clock);

      while (sent_items < RANDOM_ITEMS) begin
         steady = (run_index >= 2 && run_index < 6);
         if (run_index == 8) begin
            req_valid <= 1'b0;
            while (expected_sorted.size() != 0) @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            run_len = $urandom_range(1, 12);
         end else if (pick < 90) begin
            run_len = $urandom_range(13, HELD_CAP);
         end else begin
            run_len = $urandom_range(HELD_CAP + 1, HELD_CAP + 16);
         end
         dup_mode = 1'($urandom_range(0, 1));
         for (int k = 0; k < run_len; k++) begin
            value = dup_mode ? byte_type'($urandom_range(0, 3) * 8'h55)
                             : byte_type'($urandom_range(0, 255));
            issue_byte(value, (k == run_len - 1), 1'b0, 8'h00, 0, 1'b0);
         end
         sent_items += run_len;
         run_index++;
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      while (expected_sorted.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (sort_mismatches == 0 && expected_sorted.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/bms_pkg.sv
sv/byte_merge_sorter.sv
sim/testbench.sv
